[rtl/two_wire_master_sequencer_macros.svh]
// Assertion macros used by the two-wire master sequencer checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TWO_WIRE_MASTER_SEQUENCER_MACROS_SVH
`define TWO_WIRE_MASTER_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define TWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tws_pkg.sv]
// Types and constants of the two-wire master sequencer.
// No dependencies; imported by every module of the block.
package tws_pkg;

  // Configuration port address width (four 32-bit registers)
  localparam int unsigned CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_TARGET_ADDRESS = 2'd0,
    REG_SEND_LENGTH    = 2'd1,
    REG_RECEIVE_LENGTH = 2'd2,
    REG_TRANSFER_MODE  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2
  } cmd_e;

  // Transfer modes; the third and fourth codes act as write then read
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_STOP  = 3'd5,
    ACT_END   = 3'd6
  } act_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ARB       = 3'd1,
    ERR_ADDR_NACK = 3'd2,
    ERR_DATA_NACK = 3'd3,
    ERR_NO_INFO   = 3'd4,
    ERR_BUS       = 3'd5,
    ERR_ILLEGAL   = 3'd6
  } err_e;

  // Standard two-wire master status codes
  localparam logic [7:0] ST_BUS_ERR      = 8'h00;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RSTART       = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;
  localparam logic [7:0] ST_NO_INFO      = 8'hF8;

  typedef struct packed {
    logic [6:0] target_address;
    logic [4:0] send_length;
    logic [7:0] receive_length;
    logic [1:0] transfer_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_count;
    logic       write_pending;
    logic       read_pending;
    logic       read_dir;
    logic       running;
    err_e       last_error;
  } state_t;

  typedef struct packed {
    act_e       action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       finished;
    err_e       error_code;
  } result_t;

endpackage

[rtl/tws_step.sv]
// Per-beat decision logic of the two-wire master sequencer.
// Depends on tws_pkg; purely combinational, state is held by the top level.
module tws_step import tws_pkg::*; #(
  parameter int unsigned SEND_DEPTH = 16
) (
  input  cfg_t       cfg_i,
  input  state_t     state_i,
  input  logic [1:0] cmd_i,
  input  logic [7:0] status_code_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] store_rd_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic [8:0] depth_w;
  logic [8:0] send_len_w;
  logic [8:0] write_len;
  logic [8:0] count_w;
  logic [8:0] rx_len_w;
  logic       advance;

  // Write length is the send length clipped to the store depth
  assign depth_w    = 9'(SEND_DEPTH);
  assign send_len_w = {4'd0, cfg_i.send_length};
  assign write_len  = (send_len_w < depth_w) ? send_len_w : depth_w;
  assign count_w    = {1'b0, state_i.byte_count};
  assign rx_len_w   = {1'b0, cfg_i.receive_length};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.action = ACT_NONE;
    advance = 1'b0;

    case (cmd_e'(cmd_i))
      CMD_START: begin
        // Arm the phases and open the first one at once
        state_o.running    = 1'b1;
        state_o.last_error = ERR_NONE;
        state_o.byte_count = '0;
        state_o.write_pending = 1'b0;
        if (cfg_i.transfer_mode == MODE_READ) begin
          state_o.read_dir     = 1'b1;
          state_o.read_pending = 1'b0;
        end else begin
          state_o.read_dir     = 1'b0;
          state_o.read_pending = (cfg_i.transfer_mode != MODE_WRITE);
        end
        result_o.action = ACT_START;
      end
      CMD_EVENT: begin
        if (state_i.running) begin
          case (status_code_i) inside
            ST_START, ST_RSTART: begin
              result_o.action  = ACT_SEND;
              result_o.tx_byte = {cfg_i.target_address, state_i.read_dir};
            end
            ST_ARB_LOST: begin
              state_o.last_error = ERR_ARB;
              state_o.running    = 1'b0;
              result_o.action    = ACT_END;
            end
            ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
              if (state_i.read_dir) begin
                state_o.last_error = ERR_ILLEGAL;
                state_o.running    = 1'b0;
                result_o.action    = ACT_END;
              end else if (count_w < write_len) begin
                result_o.action    = ACT_SEND;
                result_o.tx_byte   = store_rd_i;
                state_o.byte_count = state_i.byte_count + 8'd1;
              end else begin
                advance = 1'b1;
              end
            end
            ST_SLA_W_NACK, ST_SLA_R_NACK: begin
              state_o.last_error = ERR_ADDR_NACK;
              state_o.running    = 1'b0;
              result_o.action    = ACT_STOP;
            end
            ST_DATA_TX_NACK: begin
              state_o.last_error = ERR_DATA_NACK;
              state_o.running    = 1'b0;
              result_o.action    = ACT_STOP;
            end
            ST_SLA_R_ACK: begin
              if (state_i.read_dir) begin
                result_o.action = ((count_w + 9'd1) < rx_len_w) ? ACT_ACK : ACT_NACK;
              end else begin
                state_o.last_error = ERR_ILLEGAL;
                state_o.running    = 1'b0;
                result_o.action    = ACT_END;
              end
            end
            ST_DATA_RX_ACK, ST_DATA_RX_NACK: begin
              if (!state_i.read_dir) begin
                state_o.last_error = ERR_ILLEGAL;
                state_o.running    = 1'b0;
                result_o.action    = ACT_END;
              end else begin
                // Deliver the byte only while inside the receive length
                if (count_w < rx_len_w) begin
                  result_o.rx_valid  = 1'b1;
                  result_o.rx_byte   = data_byte_i;
                  result_o.rx_index  = state_i.byte_count;
                  state_o.byte_count = state_i.byte_count + 8'd1;
                end
                if (status_code_i == ST_DATA_RX_ACK) begin
                  result_o.action = (({1'b0, state_o.byte_count} + 9'd1) < rx_len_w) ?
                                    ACT_ACK : ACT_NACK;
                end else begin
                  advance = 1'b1;
                end
              end
            end
            ST_NO_INFO: begin
              state_o.last_error = ERR_NO_INFO;
              state_o.running    = 1'b0;
              result_o.action    = ACT_END;
            end
            ST_BUS_ERR: begin
              state_o.last_error = ERR_BUS;
              state_o.running    = 1'b0;
              result_o.action    = ACT_STOP;
            end
            default: begin
              state_o.last_error = ERR_ILLEGAL;
              state_o.running    = 1'b0;
              result_o.action    = ACT_END;
            end
          endcase
        end
      end
      default: begin
        // Loads only touch the send store; the unused code does nothing
      end
    endcase

    // Phase done: repeated start into the next phase, or stop
    if (advance) begin
      state_o.byte_count = '0;
      if (state_o.write_pending) begin
        state_o.read_dir      = 1'b0;
        state_o.write_pending = 1'b0;
        result_o.action       = ACT_START;
      end else if (state_o.read_pending) begin
        state_o.read_dir     = 1'b1;
        state_o.read_pending = 1'b0;
        result_o.action      = ACT_START;
      end else begin
        state_o.running = 1'b0;
        result_o.action = ACT_STOP;
      end
    end

    result_o.finished   = !state_o.running;
    result_o.error_code = state_o.last_error;
  end

endmodule

[rtl/tws_skid.sv]
// Two-entry result buffer between the decision logic and the output port.
// Depends on tws_pkg for the result beat type.
module tws_skid import tws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  logic    head_vld_q;
  logic    tail_vld_q;
  result_t head_q;
  result_t tail_q;
  logic    pop;

  assign pop     = head_vld_q && !stall_i;
  assign full_o  = tail_vld_q;
  assign valid_o = head_vld_q;
  assign data_o  = head_q;

  // Track occupancy; a push never meets a full buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else if (pop) begin
      if (tail_vld_q) begin
        tail_vld_q <= push_i;
      end else begin
        head_vld_q <= push_i;
      end
    end else if (push_i) begin
      if (head_vld_q) begin
        tail_vld_q <= 1'b1;
      end else begin
        head_vld_q <= 1'b1;
      end
    end
  end

  // Move beats through the two slots
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (tail_vld_q) begin
        head_q <= tail_q;
        if (push_i) begin
          tail_q <= data_i;
        end
      end else if (push_i) begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      if (head_vld_q) begin
        tail_q <= data_i;
      end else begin
        head_q <= data_i;
      end
    end
  end

endmodule

[rtl/two_wire_master_sequencer.sv]
// Two-wire master sequencer: one bus action decided per input beat.
// Results are registered into a two-entry output buffer that absorbs stalls.
// Throughput: one beat per cycle while that buffer is not full, set by the
// single decision stage and the send store's one registered read port.
// Reset clears the registers, the sequencing state and the buffer; the send
// store is not cleared and holds undefined data until loaded.
module two_wire_master_sequencer import tws_pkg::*; #(
  parameter int unsigned SEND_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        status_code_i,
  input  logic [7:0]        data_byte_i,
  input  logic [3:0]        load_index_i,
  // Output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        action_o,
  output logic [7:0]        tx_byte_o,
  output logic              rx_valid_o,
  output logic [7:0]        rx_byte_o,
  output logic [7:0]        rx_index_o,
  output logic              finished_o,
  output logic [2:0]        error_code_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;

  cfg_t       cfg_q;
  state_t     state_q;
  state_t     state_d;
  state_t     state_nxt;
  result_t    result;
  result_t    head;
  logic       accept;
  logic       full;
  logic       cfg_we;
  logic [8:0] load_idx_w;
  logic [8:0] rd_cnt_w;
  logic       store_we;
  logic [AW-1:0] store_wa;
  logic [AW-1:0] store_ra;
  logic [7:0] store_rd_q;
  logic [7:0] store_mem [SEND_DEPTH];

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        REG_TARGET_ADDRESS: cfg_q.target_address <= pwdata[6:0];
        REG_SEND_LENGTH:    cfg_q.send_length    <= pwdata[4:0];
        REG_RECEIVE_LENGTH: cfg_q.receive_length <= pwdata[7:0];
        REG_TRANSFER_MODE:  cfg_q.transfer_mode  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_TARGET_ADDRESS: prdata = {25'd0, cfg_q.target_address};
      REG_SEND_LENGTH:    prdata = {27'd0, cfg_q.send_length};
      REG_RECEIVE_LENGTH: prdata = {24'd0, cfg_q.receive_length};
      REG_TRANSFER_MODE:  prdata = {30'd0, cfg_q.transfer_mode};
      default:            prdata = '0;
    endcase
  end

  // Decide the action for this beat
  tws_step #(
    .SEND_DEPTH(SEND_DEPTH)
  ) u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .cmd_i         (cmd_i),
    .status_code_i (status_code_i),
    .data_byte_i   (data_byte_i),
    .store_rd_i    (store_rd_q),
    .state_o       (state_nxt),
    .result_o      (result)
  );

  assign state_d = accept ? state_nxt : state_q;

  // Hold the sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Send store: load port, and a read of the entry at the next byte count
  assign load_idx_w = {5'd0, load_index_i};
  assign store_we   = accept && (cmd_e'(cmd_i) == CMD_LOAD) &&
                      (load_idx_w < 9'(SEND_DEPTH));
  assign store_wa   = load_idx_w[AW-1:0];
  assign rd_cnt_w   = {1'b0, state_d.byte_count};
  assign store_ra   = (rd_cnt_w < 9'(SEND_DEPTH)) ? rd_cnt_w[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_wa] <= data_byte_i;
    end
    store_rd_q <= (store_we && (store_wa == store_ra)) ? data_byte_i : store_mem[store_ra];
  end

  // Buffer result beats toward the output
  tws_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (head)
  );

  assign action_o     = head.action;
  assign tx_byte_o    = head.tx_byte;
  assign rx_valid_o   = head.rx_valid;
  assign rx_byte_o    = head.rx_byte;
  assign rx_index_o   = head.rx_index;
  assign finished_o   = head.finished;
  assign error_code_o = head.error_code;

endmodule

[rtl/tws_checker.sv]
// Port-level checks of the two-wire master sequencer, bound to the top level.
// Depends on tws_pkg and two_wire_master_sequencer_macros.svh.
`include "two_wire_master_sequencer_macros.svh"

module tws_checker import tws_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [7:0] tx_byte_o,
  input logic       rx_valid_o,
  input logic [7:0] rx_byte_o,
  input logic [7:0] rx_index_o,
  input logic       finished_o
);

  // A delivered byte comes only with a receive-side action
  `TWS_ASSERT_NOW(a_rx_action, out_valid_o && rx_valid_o, action_o == ACT_ACK || action_o == ACT_NACK || action_o == ACT_START || action_o == ACT_STOP, "rx byte with non-receive action")

  // Only a send carries a transmit byte
  `TWS_ASSERT_NOW(a_tx_zero, out_valid_o && (action_o != ACT_SEND), tx_byte_o == 8'd0, "tx byte set without send")

  // No receive payload without a delivered byte
  `TWS_ASSERT_NOW(a_rx_zero, out_valid_o && !rx_valid_o, rx_byte_o == 8'd0 && rx_index_o == 8'd0, "rx payload set without rx_valid")

  // A stop or an end leaves the block idle
  `TWS_ASSERT_NOW(a_end_idle, out_valid_o && (action_o == ACT_STOP || action_o == ACT_END), finished_o, "stop or end while still running")

  // Hold a stalled beat
  `TWS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(action_o) && $stable(tx_byte_o), "stalled output beat changed")

endmodule

bind two_wire_master_sequencer tws_checker u_tws_checker (.*);
